// ===== design/adam_pkg.sv =====
// adam_pkg: shared types and constants of the adam optimizer update block
// used by adam_ctrl, adam_dp, adam_div, adam_sqrt and the top level
package adam_pkg;

	localparam int IDX_W   = 8;
	localparam int SLOTS   = 256;
	localparam int WORD_W  = 32;
	localparam int VMOM_W  = 48;
	localparam int STEP_W  = 16;
	localparam int BETA_W  = 16;
	localparam int LR_W    = 24;
	localparam int CFG_W   = 24;
	localparam int CFG_IW  = 2;
	localparam int DIV_RW  = 41;
	localparam int DIV_QW  = 56;
	localparam int SQ_XW   = 64;
	localparam int SQ_RW   = 32;
	localparam int CNT_W   = 6;
	localparam int IN_DW   = 80;
	localparam int OUT_DW  = 64;

	localparam logic [CFG_IW-1:0] REG_BETA1 = 2'd0;
	localparam logic [CFG_IW-1:0] REG_BETA2 = 2'd1;
	localparam logic [CFG_IW-1:0] REG_LR    = 2'd2;
	localparam logic [CFG_IW-1:0] REG_EPS   = 2'd3;

	localparam logic [15:0] BETA1_RST = 16'd58982;
	localparam logic [15:0] BETA2_RST = 16'd65470;
	localparam logic [23:0] LR_RST    = 24'd16777;
	localparam logic [15:0] EPS_RST   = 16'd1;

	// datapath commands, one per cycle
	localparam int OP_W = 5;
	localparam logic [OP_W-1:0] OP_NONE    = 5'd0;
	localparam logic [OP_W-1:0] OP_LOAD    = 5'd1;
	localparam logic [OP_W-1:0] OP_POW1    = 5'd2;
	localparam logic [OP_W-1:0] OP_POW2    = 5'd3;
	localparam logic [OP_W-1:0] OP_MA      = 5'd4;
	localparam logic [OP_W-1:0] OP_MB      = 5'd5;
	localparam logic [OP_W-1:0] OP_GA      = 5'd6;
	localparam logic [OP_W-1:0] OP_VA      = 5'd7;
	localparam logic [OP_W-1:0] OP_VB      = 5'd8;
	localparam logic [OP_W-1:0] OP_MH_SET  = 5'd9;
	localparam logic [OP_W-1:0] OP_MH_GET  = 5'd10;
	localparam logic [OP_W-1:0] OP_VH_SET  = 5'd11;
	localparam logic [OP_W-1:0] OP_VH_GET  = 5'd12;
	localparam logic [OP_W-1:0] OP_SQ_SET  = 5'd13;
	localparam logic [OP_W-1:0] OP_SQ_GET  = 5'd14;
	localparam logic [OP_W-1:0] OP_PA      = 5'd15;
	localparam logic [OP_W-1:0] OP_PB      = 5'd16;
	localparam logic [OP_W-1:0] OP_U_SET   = 5'd17;
	localparam logic [OP_W-1:0] OP_U_GET   = 5'd18;
	localparam logic [OP_W-1:0] OP_FIN     = 5'd19;
	localparam logic [OP_W-1:0] OP_RESTART = 5'd20;

	typedef struct packed {
		logic [OP_W-1:0] op;
	} cmd_t;

	typedef struct packed {
		logic div_busy;
		logic sqrt_busy;
		logic out_free;
	} status_t;

endpackage

// ===== design/adam_div.sv =====
// adam_div: radix-2 restoring divider, one quotient bit per cycle
// depends on adam_pkg; user must start remainder below divisor (not checked)
module adam_div (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [adam_pkg::DIV_RW-1:0]  rem_init,
	input  logic [adam_pkg::DIV_RW-1:0]  dvs,
	input  logic [adam_pkg::DIV_QW-1:0]  bits,
	input  logic [adam_pkg::CNT_W-1:0]   steps,
	output logic                         busy,
	output logic [adam_pkg::DIV_QW-1:0]  quo
);
	import adam_pkg::*;

	logic              busy_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [DIV_RW-1:0] rem_q;
	logic [DIV_RW-1:0] dvs_q;
	logic [DIV_QW-1:0] src_q;
	logic [DIV_QW-1:0] quo_q;
	logic [DIV_RW:0]   trial;
	logic [DIV_RW:0]   diff;
	logic              ge;

	assign trial = {rem_q, src_q[DIV_QW-1]};
	assign ge    = trial >= {1'b0, dvs_q};
	assign diff  = trial - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= steps;
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= rem_init;
			dvs_q <= dvs;
			src_q <= bits;
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? diff[DIV_RW-1:0] : trial[DIV_RW-1:0];
			src_q <= {src_q[DIV_QW-2:0], 1'b0};
			quo_q <= {quo_q[DIV_QW-2:0], ge};
		end
	end

	assign busy = busy_q;
	assign quo  = quo_q;

endmodule

// ===== design/adam_sqrt.sv =====
// adam_sqrt: digit-by-digit integer square root, two radicand bits per cycle
// depends on adam_pkg
module adam_sqrt (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [adam_pkg::SQ_XW-1:0]  x,
	output logic                        busy,
	output logic [adam_pkg::SQ_RW-1:0]  root
);
	import adam_pkg::*;

	logic              busy_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [SQ_RW+1:0]  rem_q;
	logic [SQ_RW-1:0]  root_q;
	logic [SQ_XW-1:0]  src_q;
	logic [SQ_RW+3:0]  t;
	logic [SQ_RW+3:0]  trial;
	logic              ge;
	logic [SQ_RW+3:0]  diff;

	assign t     = {rem_q, src_q[SQ_XW-1:SQ_XW-2]};
	assign trial = {2'b00, root_q, 2'b01};
	assign ge    = t >= trial;
	assign diff  = t - trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CNT_W'(SQ_RW);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= '0;
			root_q <= '0;
			src_q  <= x;
		end else if (busy_q) begin
			rem_q  <= ge ? diff[SQ_RW+1:0] : t[SQ_RW+1:0];
			root_q <= {root_q[SQ_RW-2:0], ge};
			src_q  <= {src_q[SQ_XW-3:0], 2'b00};
		end
	end

	assign busy = busy_q;
	assign root = root_q;

endmodule

// ===== design/adam_dp.sv =====
// adam_dp: datapath with configuration, moment memories, step and powers
// depends on adam_pkg, adam_div and adam_sqrt
module adam_dp (
	input  logic                         clk,
	input  logic                         arst_n,
	input  adam_pkg::cmd_t               cmd,
	output adam_pkg::status_t            status,
	input  logic                         cfg_we,
	input  logic [adam_pkg::CFG_IW-1:0]  cfg_index,
	input  logic [adam_pkg::CFG_W-1:0]   cfg_wdata,
	input  logic [adam_pkg::IN_DW-1:0]   in_data,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [adam_pkg::OUT_DW-1:0]  out_data
);
	import adam_pkg::*;

	// configuration
	logic [BETA_W-1:0] b1_q, b2_q, eps_q;
	logic [LR_W-1:0]   lr_q;

	// item
	logic                     first_q;
	logic [IDX_W-1:0]         idx_q;
	logic signed [WORD_W-1:0] g_q, w_q;

	// state
	logic [WORD_W-1:0] m_mem [SLOTS];
	logic [VMOM_W-1:0] v_mem [SLOTS];
	logic [SLOTS-1:0]  vld_q;
	logic [WORD_W-1:0] m_rd_q;
	logic [VMOM_W-1:0] v_rd_q;
	logic              vld_rd_q;
	logic [STEP_W-1:0] step_q;
	logic [WORD_W-1:0] p1_q, p2_q;

	// work registers
	logic signed [48:0]        pa_q;
	logic signed [WORD_W-1:0]  m_new_q;
	logic [VMOM_W-1:0]         g2_q;
	logic [63:0]               pv_q;
	logic [VMOM_W-1:0]         v_new_q;
	logic                      sat1_q, sat2_q;
	logic [39:0]               mhat_q;
	logic [VMOM_W-1:0]         vhat_q;
	logic [32:0]               den_q;
	logic [63:0]               prod_q;
	logic [DIV_QW-1:0]         u_q;

	// output register
	logic              out_valid_q;
	logic [WORD_W-1:0] o_w_q;
	logic [IDX_W-1:0]  o_idx_q;
	logic [STEP_W-1:0] o_step_q;
	logic              o_sat_q;

	// input fields
	logic [IDX_W-1:0] in_idx;
	assign in_idx = in_data[7:0];

	// combinational datapath pieces
	logic signed [WORD_W-1:0] m_old;
	logic [VMOM_W-1:0]        v_old;
	logic [47:0]              p1_prod, p2_prod;
	logic signed [16:0]       b1s;
	logic signed [48:0]       ma_prod;
	logic [16:0]              c1, c2;
	logic signed [17:0]       c1s;
	logic signed [49:0]       mb_prod;
	logic signed [50:0]       s_sum;
	logic [WORD_W-1:0]        g_mag, m_mag;
	logic [63:0]              g_sq;
	logic [63:0]              va_prod;
	logic [64:0]              vb_prod;
	logic [64:0]              vb_sum;
	logic [32:0]              d1, d2;
	logic [15:0]              eps_eff;
	logic [43:0]              pl_prod;
	logic signed [57:0]       res;
	logic                     res_sat;

	// divider and root unit
	logic                 div_start, sq_start, div_busy, sq_busy;
	logic [DIV_RW-1:0]    div_rem, div_dvs;
	logic [DIV_QW-1:0]    div_bits, div_quo;
	logic [CNT_W-1:0]     div_steps;
	logic [SQ_RW-1:0]     sq_root;

	assign m_old   = vld_rd_q ? m_rd_q : '0;
	assign v_old   = vld_rd_q ? v_rd_q : '0;
	assign p1_prod = p1_q * b1_q;
	assign p2_prod = p2_q * b2_q;
	assign b1s     = {1'b0, b1_q};
	assign ma_prod = b1s * m_old;
	assign c1      = 17'h10000 - {1'b0, b1_q};
	assign c2      = 17'h10000 - {1'b0, b2_q};
	assign c1s     = {1'b0, c1};
	assign mb_prod = c1s * g_q;
	assign s_sum   = {{2{pa_q[48]}}, pa_q} + {mb_prod[49], mb_prod};
	assign g_mag   = g_q[WORD_W-1] ? (~g_q + 1'b1) : g_q;
	assign m_mag   = m_new_q[WORD_W-1] ? (~m_new_q + 1'b1) : m_new_q;
	assign g_sq    = g_mag * g_mag;
	assign va_prod = b2_q * v_old;
	assign vb_prod = c2 * g2_q;
	assign vb_sum  = {1'b0, pv_q} + vb_prod;
	assign d1      = 33'h1_0000_0000 - {1'b0, p1_q};
	assign d2      = 33'h1_0000_0000 - {1'b0, p2_q};
	assign eps_eff = (eps_q == '0) ? 16'd1 : eps_q;
	assign pl_prod = lr_q * (cmd.op == OP_PA ? mhat_q[19:0] : mhat_q[39:20]);
	assign res     = m_new_q[WORD_W-1]
		? ({{26{w_q[31]}}, w_q} + {2'b00, u_q})
		: ({{26{w_q[31]}}, w_q} - {2'b00, u_q});
	assign res_sat = !((res[57:31] == '0) || (res[57:31] == '1));

	always_comb begin
		div_start = 1'b0;
		div_rem   = '0;
		div_dvs   = {8'd0, d1};
		div_bits  = '0;
		div_steps = '0;
		case (cmd.op)
			OP_MH_SET: begin
				div_start = 1'b1;
				div_rem   = DIV_RW'(m_mag[31:8]);
				div_dvs   = {8'd0, d1};
				div_bits  = {m_mag[7:0], 48'd0};
				div_steps = CNT_W'(40);
			end
			OP_VH_SET: begin
				div_start = 1'b1;
				div_rem   = DIV_RW'(v_new_q[47:16]);
				div_dvs   = {8'd0, d2};
				div_bits  = {v_new_q[15:0], 40'd0};
				div_steps = CNT_W'(48);
			end
			OP_U_SET: begin
				div_start = 1'b1;
				div_rem   = DIV_RW'(prod_q[63:56]);
				div_dvs   = {den_q, 8'd0};
				div_bits  = prod_q[55:0];
				div_steps = CNT_W'(DIV_QW);
			end
			default: begin
				div_start = 1'b0;
			end
		endcase
	end

	assign sq_start = (cmd.op == OP_SQ_SET);

	adam_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.rem_init (div_rem),
		.dvs      (div_dvs),
		.bits     (div_bits),
		.steps    (div_steps),
		.busy     (div_busy),
		.quo      (div_quo)
	);

	adam_sqrt u_sqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (sq_start),
		.x      ({vhat_q, 16'd0}),
		.busy   (sq_busy),
		.root   (sq_root)
	);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			b1_q  <= BETA1_RST;
			b2_q  <= BETA2_RST;
			lr_q  <= LR_RST;
			eps_q <= EPS_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_BETA1: b1_q  <= cfg_wdata[15:0];
				REG_BETA2: b2_q  <= cfg_wdata[15:0];
				REG_LR:    lr_q  <= cfg_wdata;
				REG_EPS:   eps_q <= cfg_wdata[15:0];
				default:   b1_q  <= b1_q;
			endcase
		end
	end

	// moment memories, registered read
	always_ff @(posedge clk) begin
		if (cmd.op == OP_LOAD) begin
			m_rd_q <= m_mem[in_idx];
			v_rd_q <= v_mem[in_idx];
		end
		if (cmd.op == OP_VB) begin
			m_mem[idx_q] <= m_new_q;
			v_mem[idx_q] <= vb_sum[63:16];
		end
	end

	// control state: valid bits, step, powers, output handshake
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q       <= '0;
			vld_rd_q    <= 1'b0;
			step_q      <= '0;
			p1_q        <= '1;
			p2_q        <= '1;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (cmd.op)
				OP_LOAD: vld_rd_q <= vld_q[in_idx];
				OP_POW1: begin
					if (first_q) begin
						if (step_q != '1) begin
							step_q <= step_q + 1'b1;
						end
						p1_q <= p1_prod[47:16];
					end
				end
				OP_POW2: begin
					if (first_q) begin
						p2_q <= p2_prod[47:16];
					end
				end
				OP_VB: vld_q[idx_q] <= 1'b1;
				OP_FIN: out_valid_q <= 1'b1;
				OP_RESTART: begin
					vld_q       <= '0;
					step_q      <= '0;
					p1_q        <= '1;
					p2_q        <= '1;
					out_valid_q <= 1'b1;
				end
				default: vld_rd_q <= vld_rd_q;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_LOAD: begin
				idx_q   <= in_idx;
				first_q <= in_data[8];
				g_q     <= in_data[40:9];
				w_q     <= in_data[72:41];
			end
			OP_MA:     pa_q    <= ma_prod;
			OP_MB:     m_new_q <= s_sum[47:16];
			OP_GA:     g2_q    <= g_sq[63:16];
			OP_VA:     pv_q    <= va_prod;
			OP_VB:     v_new_q <= vb_sum[63:16];
			OP_MH_SET: sat1_q  <= {9'd0, m_mag} >= {d1, 8'd0};
			OP_MH_GET: mhat_q  <= sat1_q ? '1 : div_quo[39:0];
			OP_VH_SET: sat2_q  <= {16'd0, v_new_q} >= {d2, 16'd0};
			OP_VH_GET: vhat_q  <= sat2_q ? '1 : div_quo[47:0];
			OP_SQ_GET: den_q   <= {1'b0, sq_root} + {17'd0, eps_eff};
			OP_PA:     prod_q  <= {20'd0, pl_prod};
			OP_PB:     prod_q  <= prod_q + {pl_prod, 20'd0};
			OP_U_GET:  u_q     <= div_quo;
			OP_FIN: begin
				o_idx_q  <= idx_q;
				o_step_q <= step_q;
				o_sat_q  <= res_sat;
				if (res_sat) begin
					o_w_q <= res[57] ? 32'h8000_0000 : 32'h7FFF_FFFF;
				end else begin
					o_w_q <= res[31:0];
				end
			end
			OP_RESTART: begin
				o_idx_q  <= idx_q;
				o_step_q <= '0;
				o_sat_q  <= 1'b0;
				o_w_q    <= '0;
			end
			default: first_q <= first_q;
		endcase
	end

	assign status.div_busy  = div_busy;
	assign status.sqrt_busy = sq_busy;
	assign status.out_free  = !out_valid_q || out_ready;

	assign out_valid = out_valid_q;
	assign out_data  = {7'd0, o_sat_q, o_step_q, o_idx_q, o_w_q};

endmodule

// ===== design/adam_ctrl.sv =====
// adam_ctrl: sequencer of the update, one datapath command per cycle
// depends on adam_pkg
module adam_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_op,
	output logic               in_ready,
	input  adam_pkg::status_t  status,
	output adam_pkg::cmd_t     cmd
);
	import adam_pkg::*;

	localparam int ST_W = 5;
	localparam logic [ST_W-1:0] S_IDLE    = 5'd0;
	localparam logic [ST_W-1:0] S_POW1    = 5'd1;
	localparam logic [ST_W-1:0] S_POW2    = 5'd2;
	localparam logic [ST_W-1:0] S_MA      = 5'd3;
	localparam logic [ST_W-1:0] S_MB      = 5'd4;
	localparam logic [ST_W-1:0] S_GA      = 5'd5;
	localparam logic [ST_W-1:0] S_VA      = 5'd6;
	localparam logic [ST_W-1:0] S_VB      = 5'd7;
	localparam logic [ST_W-1:0] S_MH_SET  = 5'd8;
	localparam logic [ST_W-1:0] S_MH_WAIT = 5'd9;
	localparam logic [ST_W-1:0] S_VH_SET  = 5'd10;
	localparam logic [ST_W-1:0] S_VH_WAIT = 5'd11;
	localparam logic [ST_W-1:0] S_SQ_SET  = 5'd12;
	localparam logic [ST_W-1:0] S_SQ_WAIT = 5'd13;
	localparam logic [ST_W-1:0] S_PA      = 5'd14;
	localparam logic [ST_W-1:0] S_PB      = 5'd15;
	localparam logic [ST_W-1:0] S_U_SET   = 5'd16;
	localparam logic [ST_W-1:0] S_U_WAIT  = 5'd17;
	localparam logic [ST_W-1:0] S_FIN     = 5'd18;
	localparam logic [ST_W-1:0] S_RST     = 5'd19;

	logic [ST_W-1:0] state_q, state_d;

	always_comb begin
		state_d = state_q;
		cmd.op  = OP_NONE;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.op  = OP_LOAD;
					state_d = in_op ? S_RST : S_POW1;
				end
			end
			S_POW1: begin cmd.op = OP_POW1; state_d = S_POW2; end
			S_POW2: begin cmd.op = OP_POW2; state_d = S_MA; end
			S_MA:   begin cmd.op = OP_MA; state_d = S_MB; end
			S_MB:   begin cmd.op = OP_MB; state_d = S_GA; end
			S_GA:   begin cmd.op = OP_GA; state_d = S_VA; end
			S_VA:   begin cmd.op = OP_VA; state_d = S_VB; end
			S_VB:   begin cmd.op = OP_VB; state_d = S_MH_SET; end
			S_MH_SET: begin cmd.op = OP_MH_SET; state_d = S_MH_WAIT; end
			S_MH_WAIT: begin
				if (!status.div_busy) begin
					cmd.op  = OP_MH_GET;
					state_d = S_VH_SET;
				end
			end
			S_VH_SET: begin cmd.op = OP_VH_SET; state_d = S_VH_WAIT; end
			S_VH_WAIT: begin
				if (!status.div_busy) begin
					cmd.op  = OP_VH_GET;
					state_d = S_SQ_SET;
				end
			end
			S_SQ_SET: begin cmd.op = OP_SQ_SET; state_d = S_SQ_WAIT; end
			S_SQ_WAIT: begin
				if (!status.sqrt_busy) begin
					cmd.op  = OP_SQ_GET;
					state_d = S_PA;
				end
			end
			S_PA:    begin cmd.op = OP_PA; state_d = S_PB; end
			S_PB:    begin cmd.op = OP_PB; state_d = S_U_SET; end
			S_U_SET: begin cmd.op = OP_U_SET; state_d = S_U_WAIT; end
			S_U_WAIT: begin
				if (!status.div_busy) begin
					cmd.op  = OP_U_GET;
					state_d = S_FIN;
				end
			end
			// result waits here until the output register is free
			S_FIN: begin
				if (status.out_free) begin
					cmd.op  = OP_FIN;
					state_d = S_IDLE;
				end
			end
			S_RST: begin
				if (status.out_free) begin
					cmd.op  = OP_RESTART;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign in_ready = (state_q == S_IDLE);

endmodule

// ===== design/adam_optimizer_update_top.sv =====
// adam optimizer update: a request is taken only while the sequencer is idle, so
// a new request waits until the last result is in the output register; the three
// serial radix-2 divisions (40, 48 and 56 bits) and the 32-step root take most of
// the time of an update. the output register frees the input side.
// reset clears the moments (by valid bits) and the step count, sets the powers to
// all ones and loads the default decay rates, step size and epsilon.
module adam_optimizer_update_top (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [adam_pkg::CFG_IW-1:0]  cfg_index,
	input  logic [adam_pkg::CFG_W-1:0]   cfg_wdata,
	input  logic                         s_axis_tvalid,
	output logic                         s_axis_tready,
	// param_index[7:0], first_of_pass[8], gradient[40:9], weight_in[72:41]
	input  logic [adam_pkg::IN_DW-1:0]   s_axis_tdata,
	// operation[0]
	input  logic                         s_axis_tuser,
	output logic                         m_axis_tvalid,
	input  logic                         m_axis_tready,
	// weight_out[31:0], index_out[39:32], step_number[55:40], saturated[56]
	output logic [adam_pkg::OUT_DW-1:0]  m_axis_tdata
);
	import adam_pkg::*;

	cmd_t    cmd;
	status_t status;

	adam_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_op    (s_axis_tuser),
		.in_ready (s_axis_tready),
		.status   (status),
		.cmd      (cmd)
	);

	adam_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.status    (status),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.in_data   (s_axis_tdata),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (m_axis_tdata)
	);

endmodule
